// ===== src/mlfd_pkg.sv =====
// shared types and constants for the magic length frame deframer
package mlfd_pkg;

  localparam int HEADER_BYTES = 16;
  localparam int MAGIC_BYTES  = 8;
  localparam int IDX_W        = $clog2(HEADER_BYTES);
  localparam int MAGIC_IDX_W  = $clog2(MAGIC_BYTES);

  localparam logic [7:0] MAGIC_SEQ [MAGIC_BYTES] = '{
    8'h7A, 8'h54, 8'h85, 8'h40, 8'hAF, 8'h24, 8'hD0, 8'h24
  };

  // header byte positions
  localparam logic [IDX_W-1:0] IDX_SELF_LEN0 = IDX_W'(8);
  localparam logic [IDX_W-1:0] IDX_PAY_LEN0  = IDX_W'(12);
  localparam logic [IDX_W-1:0] IDX_PAY_LEN1  = IDX_W'(13);
  localparam logic [IDX_W-1:0] IDX_PAY_LEN2  = IDX_W'(14);
  localparam logic [IDX_W-1:0] IDX_LAST      = IDX_W'(HEADER_BYTES - 1);

  localparam logic [7:0]  SELF_LEN_BYTE0   = 8'(HEADER_BYTES);
  localparam logic [15:0] MAX_PAYLOAD_RST  = 16'd1499;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALT    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

endpackage

// ===== src/magic_length_frame_deframer.sv =====
// byte stream deframer: magic plus length header, payload forwarding, reject and halt
// the result of an accepted input beat is in the output register in the cycle after it is accepted
// throughput: one byte per cycle while the output register is not held full by out_stall
// a new beat is taken whenever the output register is empty or drains in the same cycle
// rst (synchronous, active high) clears the output register, returns to header search
// and sets max_payload to 1499; a rejected header halts the block until the next rst
module magic_length_frame_deframer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          kind,
  output logic [7:0]          data_byte,
  output logic                last_of_frame,
  input  logic                cfg_wen,
  input  logic [15:0]         cfg_wdata
);
  import mlfd_pkg::*;

  phase_t                phase, phase_next;
  logic [IDX_W-1:0]      header_index, header_index_next;
  logic                  header_ok, header_ok_next;
  logic                  len_hi_zero, len_hi_zero_next;
  logic [15:0]           len_low, len_low_next;
  logic [15:0]           payload_remaining, payload_remaining_next;
  logic [15:0]           max_payload;

  logic                  res_valid;
  kind_t                 res_kind;
  logic [7:0]            res_data;
  logic                  res_last;

  logic                  in_accept;
  logic                  out_free;
  logic                  byte_ok;
  logic                  legal;
  logic [15:0]           full_len;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !out_free;
  assign in_accept = in_valid && out_free;

  // per-position check of a magic, self-length or zero header byte against its only legal value
  always_comb begin
    byte_ok = 1'b1;
    if (header_index < IDX_W'(MAGIC_BYTES)) begin
      byte_ok = (in_byte == MAGIC_SEQ[header_index[MAGIC_IDX_W-1:0]]);
    end else if (header_index == IDX_SELF_LEN0) begin
      byte_ok = (in_byte == SELF_LEN_BYTE0);
    end else if (header_index < IDX_PAY_LEN0) begin
      byte_ok = (in_byte == 8'd0);
    end
  end

  assign full_len = len_low;
  assign legal    = header_ok && len_hi_zero && (in_byte == 8'd0)
                    && (full_len <= max_payload);

  always_comb begin
    phase_next             = phase;
    header_index_next      = header_index;
    header_ok_next         = header_ok;
    len_hi_zero_next       = len_hi_zero;
    len_low_next           = len_low;
    payload_remaining_next = payload_remaining;
    res_valid              = 1'b0;
    res_kind               = KIND_DATA;
    res_data               = 8'd0;
    res_last               = 1'b0;
    case (phase)
      PH_HEADER: begin
        if (header_index == IDX_PAY_LEN0) begin
          len_low_next = {8'd0, in_byte};
        end else if (header_index == IDX_PAY_LEN1) begin
          len_low_next = {in_byte, len_low[7:0]};
        end else if (header_index == IDX_PAY_LEN2) begin
          len_hi_zero_next = (in_byte == 8'd0);
        end
        if (header_index != IDX_LAST) begin
          header_ok_next    = header_ok && byte_ok;
          header_index_next = header_index + IDX_W'(1);
        end else begin
          header_index_next = '0;
          res_valid         = 1'b1;
          if (!legal) begin
            phase_next = PH_HALT;
            res_kind   = KIND_REJECT;
          end else if (full_len == 16'd0) begin
            header_ok_next = 1'b1;
            res_kind       = KIND_EMPTY;
            res_last       = 1'b1;
          end else begin
            res_valid              = 1'b0;
            payload_remaining_next = full_len;
            phase_next             = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid = 1'b1;
        res_kind  = KIND_DATA;
        res_data  = in_byte;
        if (payload_remaining <= 16'd1) begin
          res_last               = 1'b1;
          payload_remaining_next = 16'd0;
          phase_next             = PH_HEADER;
          header_index_next      = '0;
          header_ok_next         = 1'b1;
        end else begin
          payload_remaining_next = payload_remaining - 16'd1;
        end
      end
      default: begin
        // halted: beats are swallowed until reset
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      header_index      <= '0;
      header_ok         <= 1'b1;
      len_hi_zero       <= 1'b1;
      len_low           <= 16'd0;
      payload_remaining <= 16'd0;
    end else if (in_accept) begin
      phase             <= phase_next;
      header_index      <= header_index_next;
      header_ok         <= header_ok_next;
      len_hi_zero       <= len_hi_zero_next;
      len_low           <= len_low_next;
      payload_remaining <= payload_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RST;
    end else if (cfg_wen) begin
      max_payload <= cfg_wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_accept && res_valid) begin
      kind          <= res_kind;
      data_byte     <= res_data;
      last_of_frame <= res_last;
    end
  end

endmodule
